@@ sv/bis_pkg.sv @@
// Shared types and codes for the binary insertion sorter.
`timescale 1ns / 1ps

package bis_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } t_out;

    typedef struct packed {
        logic load;
        logic rd_mid;
        logic cmp;
        logic shift;
        logic put;
        logic rd_idx;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic ins_go;
        logic rd_go;
        logic search_done;
        logic shift_done;
    } t_sts;

endpackage

@@ sv/bis_ctrl.sv @@
// Sequencing state machine for the binary insertion sorter.
`timescale 1ns / 1ps

module bis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bis_pkg::t_sts i_sts,
    output bis_pkg::t_cmd o_cmd,
    output logic          busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SCMP  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_RDISS = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.ins_go) begin
                        n_state = S_SRCH;
                    end else if (i_sts.rd_go) begin
                        n_state = S_RDISS;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SRCH: begin
                if (i_sts.search_done) begin
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_SRCH;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_RESP;
            end
            S_RDISS: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ sv/bis_dp.sv @@
// Store, search bounds, shift pointer and result registers of the sorter.
`timescale 1ns / 1ps

module bis_dp #(
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bis_pkg::t_in  i_item,
    input  bis_pkg::t_cmd i_cmd,
    output bis_pkg::t_sts o_sts,
    output logic          o_valid,
    output bis_pkg::t_out o_result
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IXW = (CW > bis_pkg::INDEX_W) ? CW : bis_pkg::INDEX_W;

    logic signed [bis_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [bis_pkg::VALUE_W-1:0] r_rd_data;
    logic signed [bis_pkg::VALUE_W-1:0] r_key;
    logic [bis_pkg::OP_W-1:0]           r_op;
    logic [bis_pkg::STATUS_W-1:0]       r_stat;
    logic [bis_pkg::INDEX_W-1:0]        r_idx;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_lo;
    logic [CW-1:0]                      r_hi;
    logic [CW-1:0]                      r_mid;
    logic [CW-1:0]                      r_j;
    logic [AW-1:0]                      r_wr_addr;
    logic                               r_wr_pend;
    logic                               r_valid;
    bis_pkg::t_out                      r_result;

    logic [CW-1:0] mid;
    logic [AW-1:0] rd_addr;
    logic          full;
    logic          idx_ok;
    logic          do_shift;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign full     = (r_count == CW'(DEPTH));
    assign idx_ok   = (IXW'(i_item.index) < IXW'(r_count));
    assign do_shift = i_cmd.shift && (r_j != r_lo);

    assign o_sts.ins_go      = (i_item.op == bis_pkg::OP_INSERT) && !full;
    assign o_sts.rd_go       = (i_item.op == bis_pkg::OP_READ) && idx_ok;
    assign o_sts.search_done = (r_lo == r_hi);
    assign o_sts.shift_done  = (r_j == r_lo);

    always_comb begin
        if (i_cmd.rd_idx) begin
            rd_addr = AW'(r_idx);
        end else if (i_cmd.rd_mid) begin
            rd_addr = AW'(mid);
        end else begin
            rd_addr = AW'(r_j - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= r_rd_data;
        end else if (i_cmd.put) begin
            r_mem[AW'(r_lo)] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_item.value;
            r_op  <= i_item.op;
            r_idx <= i_item.index;
            r_lo  <= '0;
            r_hi  <= r_count;
            r_j   <= r_count;
            if (i_item.op == bis_pkg::OP_INSERT && full) begin
                r_stat <= bis_pkg::ST_FULL;
            end else if (i_item.op == bis_pkg::OP_READ && !idx_ok) begin
                r_stat <= bis_pkg::ST_RANGE;
            end else begin
                r_stat <= bis_pkg::ST_OK;
            end
        end
        if (i_cmd.rd_mid) begin
            r_mid <= mid;
        end
        if (i_cmd.cmp) begin
            if (r_rd_data > r_key) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + CW'(1);
            end
        end
        if (do_shift) begin
            r_j       <= r_j - CW'(1);
            r_wr_addr <= AW'(r_j);
        end
        if (i_cmd.respond) begin
            r_result.data   <= (r_op == bis_pkg::OP_READ && r_stat == bis_pkg::ST_OK)
                               ? r_rd_data : '0;
            r_result.status <= r_stat;
            r_result.count  <= (r_op == bis_pkg::OP_CLEAR) ? '0 : bis_pkg::COUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_wr_pend <= do_shift;
            r_valid   <= i_cmd.respond;
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.respond && r_op == bis_pkg::OP_CLEAR) begin
                r_count <= '0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ sv/binary_insertion_sorter_core.sv @@
// Top level of the binary insertion sorter: controller, datapath and checks.
`timescale 1ns / 1ps

// Keeps up to DEPTH signed 32-bit keys in ascending order in one single-port-write
// memory. Issue an item with start while busy is low; its result appears on o_result
// with o_valid high for one cycle and must be taken then. A read within the count
// first reads the addressed entry; a clear, an unused op, a read past the count or
// an insert into a full store goes straight to its result. An insert runs at most
// ceil(log2(count+1)) binary search steps, each a memory read and a compare, then
// moves each entry at or above the slot up one place, since the memory moves one
// entry per cycle, and at last writes the key into the slot.
module binary_insertion_sorter_core #(
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bis_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_valid,
    output bis_pkg::t_out o_result
);

    bis_pkg::t_cmd cmd;
    bis_pkg::t_sts sts;

    bis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    bis_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after item taken");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && !$past(o_valid))
        else $error("result strobe while busy or held");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == bis_pkg::OP_CLEAR
        |-> ##2 o_valid && o_result.count == '0 && o_result.status == bis_pkg::ST_OK)
        else $error("clear result wrong");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status != bis_pkg::ST_OK |-> o_result.data == '0)
        else $error("flagged result carries data");

endmodule

@@ tb/sv/binary_insertion_sorter_checker.sv @@
// Checker for the binary insertion sorter: predicts each result and compares it.
`timescale 1ns / 1ps

module binary_insertion_sorter_checker #(
    parameter int DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  bis_pkg::t_in   i_item,
    input  logic           i_valid,
    input  bis_pkg::t_out  i_result,
    output int             o_errors,
    output int             o_pending
);
    import bis_pkg::*;

    logic signed [VALUE_W-1:0] sorted_keys [DEPTH];
    int                        key_total = 0;
    t_out                      awaited_results [$];
    t_out                      oldest;
    int                        errors = 0;

    assign o_errors = errors;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic t_out apply_item(input t_in it);
        t_out res;
        int   lo;
        int   hi;
        int   mid;
        res = '0;
        case (it.op)
            OP_INSERT: begin
                if (key_total >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    lo = 0;
                    hi = key_total;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (sorted_keys[mid] > it.value) begin
                            hi = mid;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    for (int j = key_total; j > lo; j--) begin
                        sorted_keys[j] = sorted_keys[j-1];
                    end
                    sorted_keys[lo] = it.value;
                    key_total++;
                end
            end
            OP_READ: begin
                if (it.index < key_total) begin
                    res.data = sorted_keys[it.index];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_CLEAR: begin
                key_total = 0;
            end
            default: begin
            end
        endcase
        res.count = key_total[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_total = 0;
            awaited_results.delete();
        end else begin
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("result with no item outstanding: data %0d status %0d count %0d",
                                            i_result.data, i_result.status, i_result.count));
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_result.data !== oldest.data)
                        flag_mismatch($sformatf("data %0d, want %0d", i_result.data, oldest.data));
                    if (i_result.status !== oldest.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                i_result.status, oldest.status));
                    if (i_result.count !== oldest.count)
                        flag_mismatch($sformatf("count %0d, want %0d", i_result.count, oldest.count));
                end
            end
            if (i_start && !i_busy) begin
                awaited_results.push_back(apply_item(i_item));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ tb/sv/binary_insertion_sorter_core_tb.sv @@
// Testbench top for the binary insertion sorter: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module binary_insertion_sorter_core_tb;
    import bis_pkg::*;

    localparam int               DEPTH       = 1024;
    localparam int               CYCLE_LIMIT = 8_000_000;
    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam logic signed [31:0] KEY_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX   = 32'sh7fff_ffff;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_item  = '0;
    logic  busy;
    logic  o_valid;
    t_out  o_result;
    int    errors;
    int    pending;
    int    cycles = 0;
    int    gap_pct = 0;
    int    held = 0;
    int    clear_cap = 16;

    binary_insertion_sorter_core #(.DEPTH(DEPTH)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    binary_insertion_sorter_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_busy   (busy),
        .i_item   (i_item),
        .i_valid  (o_valid),
        .i_result (o_result),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL binary_insertion_sorter_core");
            $finish;
        end
    end

    task automatic push_item(input logic [OP_W-1:0] op, input logic signed [31:0] value,
                             input logic [INDEX_W-1:0] index);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_item.op    <= op;
        i_item.value <= value;
        i_item.index <= index;
        do @(posedge i_clk); while (busy);
        if (op == OP_INSERT && held < DEPTH) held++;
        if (op == OP_CLEAR) held = 0;
    endtask

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(4))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (r < 30) return $signed($urandom_range(15)) - 32'sd8;
        return $signed($urandom);
    endfunction

    task automatic random_item();
        int r;
        int sub;
        logic [INDEX_W-1:0] idx;
        r = $urandom_range(99);
        if (held >= clear_cap || r < 4) begin
            push_item(OP_CLEAR, $signed($urandom), INDEX_W'($urandom));
            clear_cap = $urandom_range(4, 48);
        end else if (r < 7) begin
            push_item(OP_UNUSED, $signed($urandom), INDEX_W'($urandom));
        end else if (r < 60) begin
            push_item(OP_INSERT, pick_key(), INDEX_W'($urandom));
        end else begin
            sub = $urandom_range(9);
            if (held > 0 && sub < 7) idx = INDEX_W'($urandom_range(held - 1));
            else if (sub < 9) idx = INDEX_W'(held);
            else idx = INDEX_W'($urandom);
            push_item(OP_READ, $signed($urandom), idx);
        end
    endtask

    initial begin : stimulus
        int base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item(OP_READ,   32'sd0,  10'd0);
        push_item(OP_UNUSED, KEY_MAX, 10'h3ff);
        push_item(OP_INSERT, 32'sd0,  10'd0);
        push_item(OP_INSERT, KEY_MAX, 10'd0);
        push_item(OP_INSERT, KEY_MIN, 10'd0);
        push_item(OP_INSERT, -32'sd1, 10'd0);
        push_item(OP_INSERT, 32'sd1,  10'd0);
        push_item(OP_INSERT, 32'sd0,  10'd0);
        push_item(OP_INSERT, KEY_MAX, 10'd0);
        for (int i = 0; i < 8; i++) push_item(OP_READ, 32'sd0, INDEX_W'(i));
        push_item(OP_READ,   32'sd0,  10'h3ff);
        push_item(OP_CLEAR,  32'sd0,  10'd0);
        push_item(OP_READ,   32'sd0,  10'd0);
        push_item(OP_INSERT, 32'sd5,  10'd0);
        push_item(OP_READ,   32'sd0,  10'd0);
        push_item(OP_UNUSED, 32'sd0,  10'd0);

        gap_pct = 12;
        for (int i = 0; i < 200; i++) random_item();
        gap_pct = 56;
        for (int i = 0; i < 200; i++) random_item();
        gap_pct = 0;
        for (int i = 0; i < 180; i++) random_item();

        // fill the store to capacity, mostly in ascending order to keep shifts short
        gap_pct = 12;
        push_item(OP_CLEAR, 32'sd0, 10'd0);
        base = KEY_MIN;
        while (held < DEPTH) begin
            if ($urandom_range(7) == 0) begin
                push_item(OP_READ, 32'sd0, INDEX_W'($urandom));
            end else if ($urandom_range(31) == 0) begin
                push_item(OP_INSERT, $signed($urandom), INDEX_W'($urandom));
            end else begin
                base = base + $urandom_range(4_000_000);
                push_item(OP_INSERT, base, INDEX_W'($urandom));
            end
        end
        push_item(OP_INSERT, KEY_MAX, 10'd0);
        push_item(OP_INSERT, KEY_MIN, 10'd0);
        push_item(OP_INSERT, $signed($urandom), 10'd0);
        push_item(OP_READ,   32'sd0, 10'h3ff);
        push_item(OP_READ,   32'sd0, 10'd0);
        for (int i = 0; i < 16; i++) push_item(OP_READ, 32'sd0, INDEX_W'($urandom));
        push_item(OP_UNUSED, 32'sd0, 10'd0);
        push_item(OP_CLEAR,  32'sd0, 10'd0);
        push_item(OP_READ,   32'sd0, 10'd0);
        start <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS binary_insertion_sorter_core");
        end else begin
            $display("FAIL binary_insertion_sorter_core");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/bis_pkg.sv
sv/bis_ctrl.sv
sv/bis_dp.sv
sv/binary_insertion_sorter_core.sv
tb/sv/binary_insertion_sorter_checker.sv
tb/sv/binary_insertion_sorter_core_tb.sv
